FILE: rtl/assert_macros.svh
// Assertion macros shared by the terminal RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define TTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define TTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/ttw_pkg.sv
// Shared types and constants for the text terminal writer
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int COLUMNS_DEF = 32;
    localparam int ROWS_DEF    = 16;

    localparam int CMD_COL_W  = 8;
    localparam int CMD_ROW_W  = 7;
    localparam int CMD_ADDR_W = 15;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SET   = 2'd2,
        REQ_READ  = 2'd3
    } t_req_code;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_SET,
        OP_READ
    } t_op;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         char_code;
        logic signed [15:0] col_in;
        logic signed [15:0] row_in;
    } t_req;

    typedef struct packed {
        logic [7:0] read_char;
        logic [7:0] cursor_col;
        logic [6:0] cursor_row;
        logic       scrolled;
    } t_res;

    typedef struct packed {
        t_op                   op;
        logic [7:0]            char_code;
        logic [CMD_COL_W-1:0]  col;
        logic [CMD_ROW_W-1:0]  row;
        logic [CMD_ADDR_W-1:0] addr;
    } t_cmd;

endpackage

FILE: rtl/ttw_ram.sv
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps

module ttw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ttw_front.sv
// Front end: accept requests, clamp coordinates, classify into commands
`timescale 1ns / 1ps

module ttw_front #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
    input  logic          i_valid,
    input  ttw_pkg::t_req i_req,
    input  logic          i_full,
    input  logic          i_init_busy,
    output logic          o_stall,
    output logic          o_push,
    output ttw_pkg::t_cmd o_cmd
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(COLUMNS * ROWS);
    localparam logic signed [15:0] COL_HI = 16'(COLUMNS - 1);
    localparam logic signed [15:0] ROW_HI = 16'(ROWS - 1);

    logic [CW-1:0] w_col;
    logic [RW-1:0] w_row;
    logic [AW-1:0] w_addr;

    always_comb begin
        if (i_req.col_in[15]) begin
            w_col = '0;
        end else if (i_req.col_in > COL_HI) begin
            w_col = CW'(COLUMNS - 1);
        end else begin
            w_col = i_req.col_in[CW-1:0];
        end
        if (i_req.row_in[15]) begin
            w_row = '0;
        end else if (i_req.row_in > ROW_HI) begin
            w_row = RW'(ROWS - 1);
        end else begin
            w_row = i_req.row_in[RW-1:0];
        end
    end

    assign w_addr = AW'(w_row) * AW'(COLUMNS) + AW'(w_col);

    always_comb begin
        o_cmd.char_code = i_req.char_code;
        o_cmd.col       = ttw_pkg::CMD_COL_W'(w_col);
        o_cmd.row       = ttw_pkg::CMD_ROW_W'(w_row);
        o_cmd.addr      = ttw_pkg::CMD_ADDR_W'(w_addr);
        unique case (i_req.req_type)
            ttw_pkg::REQ_PUT: begin
                o_cmd.op = (i_req.char_code == ttw_pkg::NEWLINE_CODE) ?
                           ttw_pkg::OP_NEWLINE : ttw_pkg::OP_PUT;
            end
            ttw_pkg::REQ_CLEAR: o_cmd.op = ttw_pkg::OP_CLEAR;
            ttw_pkg::REQ_SET:   o_cmd.op = ttw_pkg::OP_SET;
            default:            o_cmd.op = ttw_pkg::OP_READ;
        endcase
    end

    assign o_stall = i_full || i_init_busy;
    assign o_push  = i_valid && !o_stall;

endmodule

FILE: rtl/ttw_queue.sv
// Two-entry command queue between front and back end
`timescale 1ns / 1ps

module ttw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ttw_pkg::t_cmd o_cmd
);

    ttw_pkg::t_cmd r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

endmodule

FILE: rtl/ttw_back.sv
// Back end: cursor, screen store, scroll and clear sweeps, result register
`timescale 1ns / 1ps

module ttw_back #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ttw_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_init_busy,
    output logic          o_valid,
    output ttw_pkg::t_res o_res,
    input  logic          i_stall
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_LIN = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_FILL,
        S_CLEAR
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_cnt;
    logic            r_pend;
    logic [AW-1:0]   r_pend_addr;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [AW-1:0]   r_lin;
    logic            r_out_valid;
    ttw_pkg::t_res   r_out;

    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [AW-1:0]   n_lin;
    logic            n_scroll;

    logic            w_pop;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [7:0]      w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_rdata;

    assign w_pop = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || !i_stall);

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_lin    = r_lin;
        n_scroll = 1'b0;
        case (i_cmd.op)
            ttw_pkg::OP_PUT: begin
                if (r_col == LAST_COL) begin
                    if (r_row == LAST_ROW) begin
                        n_scroll = 1'b1;
                    end else begin
                        n_col = '0;
                        n_row = RW'(r_row + 1'b1);
                        n_lin = AW'(r_lin + 1'b1);
                    end
                end else begin
                    n_col = CW'(r_col + 1'b1);
                    n_lin = AW'(r_lin + 1'b1);
                end
            end
            ttw_pkg::OP_NEWLINE: begin
                if (r_row == LAST_ROW) begin
                    n_scroll = 1'b1;
                end else begin
                    n_col = '0;
                    n_row = RW'(r_row + 1'b1);
                    n_lin = AW'(r_lin - AW'(r_col) + ROW_STRIDE);
                end
            end
            ttw_pkg::OP_CLEAR: begin
                n_col = '0;
                n_row = '0;
                n_lin = '0;
            end
            ttw_pkg::OP_SET: begin
                n_col = CW'(i_cmd.col);
                n_row = RW'(i_cmd.row);
                n_lin = AW'(i_cmd.addr);
            end
            default: begin
            end
        endcase
        if (n_scroll) begin
            n_col = '0;
            n_row = LAST_ROW;
            n_lin = BOTTOM_LIN;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = ttw_pkg::SPACE_CODE;
        if (r_pend) begin
            w_we    = 1'b1;
            w_waddr = r_pend_addr;
            w_wdata = w_rdata;
        end else begin
            unique case (r_state) inside
                S_INIT, S_CLEAR, S_FILL: w_we = 1'b1;
                S_IDLE: begin
                    if (w_pop && i_cmd.op == ttw_pkg::OP_PUT) begin
                        w_we    = 1'b1;
                        w_waddr = r_lin;
                        w_wdata = i_cmd.char_code;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_raddr = (r_state == S_COPY) ? r_cnt : AW'(i_cmd.addr);

    ttw_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_lin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= AW'(r_cnt + 1'b1);
                    end
                end
                S_IDLE: begin
                    if (w_pop) begin
                        r_col <= n_col;
                        r_row <= n_row;
                        r_lin <= n_lin;
                        if (n_scroll) begin
                            r_state <= S_COPY;
                            r_cnt   <= ROW_STRIDE;
                        end else begin
                            case (i_cmd.op)
                                ttw_pkg::OP_CLEAR: begin
                                    r_state <= S_CLEAR;
                                    r_cnt   <= '0;
                                end
                                ttw_pkg::OP_READ: r_state <= S_READ;
                                default: begin
                                    r_out_valid      <= 1'b1;
                                    r_out.read_char  <= '0;
                                    r_out.cursor_col <= 8'(n_col);
                                    r_out.cursor_row <= 7'(n_row);
                                    r_out.scrolled   <= 1'b0;
                                end
                            endcase
                        end
                    end
                end
                S_READ: begin
                    r_state          <= S_IDLE;
                    r_out_valid      <= 1'b1;
                    r_out.read_char  <= w_rdata;
                    r_out.cursor_col <= 8'(r_col);
                    r_out.cursor_row <= 7'(r_row);
                    r_out.scrolled   <= 1'b0;
                end
                S_COPY: begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= AW'(r_cnt - ROW_STRIDE);
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_FILL;
                        r_cnt   <= BOTTOM_LIN;
                    end else begin
                        r_cnt <= AW'(r_cnt + 1'b1);
                    end
                end
                S_FILL: begin
                    if (!r_pend) begin
                        if (r_cnt == LAST_CELL) begin
                            r_state          <= S_IDLE;
                            r_out_valid      <= 1'b1;
                            r_out.read_char  <= '0;
                            r_out.cursor_col <= 8'(r_col);
                            r_out.cursor_row <= 7'(r_row);
                            r_out.scrolled   <= 1'b1;
                        end else begin
                            r_cnt <= AW'(r_cnt + 1'b1);
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_cnt == LAST_CELL) begin
                        r_state          <= S_IDLE;
                        r_out_valid      <= 1'b1;
                        r_out.read_char  <= '0;
                        r_out.cursor_col <= 8'(r_col);
                        r_out.cursor_row <= 7'(r_row);
                        r_out.scrolled   <= 1'b0;
                    end else begin
                        r_cnt <= AW'(r_cnt + 1'b1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd_pop   = w_pop;
    assign o_init_busy = (r_state == S_INIT);
    assign o_valid     = r_out_valid;
    assign o_res       = r_out;

endmodule

FILE: rtl/text_terminal_writer_top.sv
// Put char, newline and set cursor pass the command queue and the result register; read cell
// also passes S_READ. A scroll walks the store once; clear fills every cell with spaces.
// Without scroll or clear the back end retires one put, newline or set per cycle unless
// i_stall holds the result; a read holds back the next command. A two-entry queue lets the
// front take requests in a sweep until full. After reset spaces fill the store, o_stall high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_terminal_writer_top #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ttw_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output ttw_pkg::t_res o_res
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_q_valid;
    logic          w_init_busy;
    ttw_pkg::t_cmd w_cmd_in;
    ttw_pkg::t_cmd w_cmd_out;

    ttw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_valid    (i_valid),
        .i_req      (i_req),
        .i_full     (w_full),
        .i_init_busy(w_init_busy),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    ttw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_cmd_in),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_cmd_out)
    );

    ttw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_q_valid),
        .i_cmd      (w_cmd_out),
        .o_cmd_pop  (w_pop),
        .o_init_busy(w_init_busy),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_stall    (i_stall)
    );

    `TTW_ASSERT(a_no_push_when_full, i_clk, i_rst_n, w_push |-> !w_full, "push into full queue")
    `TTW_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, w_pop |-> w_q_valid, "pop from empty queue")
    `TTW_ASSERT(a_cursor_in_range, i_clk, i_rst_n, o_valid |-> (o_res.cursor_row <= 7'(ROWS - 1) && o_res.cursor_col <= 8'(COLUMNS - 1)), "cursor outside screen")
    `TTW_ASSERT(a_scroll_home, i_clk, i_rst_n, (o_valid && o_res.scrolled) |-> (o_res.cursor_row == 7'(ROWS - 1) && o_res.cursor_col == 8'd0 && o_res.read_char == 8'd0), "scroll left cursor off bottom row start")
    `TTW_ASSERT_ALWAYS(a_stall_after_reset, i_clk, $past(!i_rst_n) |-> o_stall, "request accepted during clearing pass")

endmodule
